[rtl/cdq_pkg.sv]
package cdq_pkg;

  localparam int CMD_W      = 3;
  localparam int DATA_W     = 32;
  localparam int CAP_W      = 5;
  localparam int CAP_RESET  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic read;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_status_t;

endpackage

[rtl/cdq_if.sv]
interface cdq_req_if;
  logic                              valid;
  logic                              ready;
  logic [cdq_pkg::CMD_W-1:0]         cmd;
  logic signed [cdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic signed [cdq_pkg::DATA_W-1:0] front_value;
  logic signed [cdq_pkg::DATA_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;

  modport source (output valid, output accepted, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

[rtl/cdq_ram.sv]
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/cdq_ctrl.sv]
module cdq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cdq_pkg::dp_status_t   status,
  output cdq_pkg::ctrl_cmd_t    ctrl
);

  cdq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cdq_pkg::ST_IDLE: begin
        if (in_valid) state_next = cdq_pkg::ST_EXEC;
      end
      cdq_pkg::ST_EXEC: state_next = cdq_pkg::ST_READ;
      cdq_pkg::ST_READ: state_next = cdq_pkg::ST_LOAD;
      cdq_pkg::ST_LOAD: begin
        // hold until the output register is free
        if (!status.out_stall) state_next = cdq_pkg::ST_IDLE;
      end
      default: state_next = cdq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == cdq_pkg::ST_IDLE);
    ctrl.capture = (state == cdq_pkg::ST_IDLE) && in_valid;
    ctrl.exec    = (state == cdq_pkg::ST_EXEC);
    ctrl.read    = (state == cdq_pkg::ST_READ);
    ctrl.load    = (state == cdq_pkg::ST_LOAD) && !status.out_stall;
  end

endmodule

[rtl/cdq_datapath.sv]
module cdq_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]         cfg_wdata,
  input  logic [cdq_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [cdq_pkg::DATA_W-1:0] in_value,
  input  cdq_pkg::ctrl_cmd_t                ctrl,
  output cdq_pkg::dp_status_t               status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              accepted,
  output logic signed [cdq_pkg::DATA_W-1:0] front_value,
  output logic signed [cdq_pkg::DATA_W-1:0] rear_value,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int DEPTH = MAX_ENTRIES + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int CAP_INIT = (MAX_ENTRIES < cdq_pkg::CAP_RESET) ? MAX_ENTRIES
                                                               : cdq_pkg::CAP_RESET;

  logic [PW-1:0] cap, head, tail, count;
  logic [PW-1:0] head_next, tail_next, count_next;
  logic [PW-1:0] cap_wr;
  logic [cdq_pkg::CMD_W-1:0]  cmd_q;
  logic [cdq_pkg::DATA_W-1:0] value_q;
  logic                       ok, ok_q;
  logic                       wr_en;
  logic [PW-1:0]              wr_addr;
  logic [PW-1:0]              rd_addr_a, rd_addr_b;
  logic [cdq_pkg::DATA_W-1:0] rd_data_a, rd_data_b;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p, input logic [PW-1:0] c);
    return (p >= c) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p, input logic [PW-1:0] c);
    return (p == '0 || p > c) ? c : p - PW'(1);
  endfunction

  // saturate the written capacity into 1..MAX_ENTRIES
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_wr = PW'(1);
    end else if (int'(cfg_wdata) > MAX_ENTRIES) begin
      cap_wr = PW'(MAX_ENTRIES);
    end else begin
      cap_wr = PW'(cfg_wdata);
    end
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ok         = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = head;
    case (cdq_pkg::cmd_t'(cmd_q))
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (count >= cap) begin
          ok = 1'b0;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = head;
          head_next  = ptr_dec(head, cap);
          count_next = count + PW'(1);
        end
      end
      cdq_pkg::CMD_PUSH_BACK: begin
        if (count >= cap) begin
          ok = 1'b0;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = tail;
          tail_next  = ptr_inc(tail, cap);
          count_next = count + PW'(1);
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (count == '0) begin
          ok = 1'b0;
        end else begin
          head_next  = ptr_inc(head, cap);
          count_next = count - PW'(1);
        end
      end
      cdq_pkg::CMD_POP_BACK: begin
        if (count == '0) begin
          ok = 1'b0;
        end else begin
          tail_next  = ptr_dec(tail, cap);
          count_next = count - PW'(1);
        end
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= PW'(CAP_INIT);
      head  <= '0;
      tail  <= PW'(1);
      count <= '0;
    end else if (cfg_we) begin
      cap   <= cap_wr;
      head  <= '0;
      tail  <= PW'(1);
      count <= '0;
    end else if (ctrl.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q   <= in_cmd;
      value_q <= in_value;
    end
    if (ctrl.exec) begin
      ok_q <= ok;
    end
  end

  assign rd_addr_a = ptr_inc(head, cap);
  assign rd_addr_b = ptr_dec(tail, cap);

  cdq_ram #(
    .WIDTH (cdq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .we      (ctrl.exec && wr_en),
    .waddr   (wr_addr),
    .wdata   (value_q),
    .re      (ctrl.read),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      accepted    <= ok_q;
      front_value <= (count == '0) ? '1 : rd_data_a;
      rear_value  <= (count == '0) ? '1 : rd_data_b;
      is_empty    <= (count == '0);
      is_full     <= (count == cap);
    end
  end

  assign status.out_stall = out_valid && !out_ready;

endmodule

[rtl/circular_deque_core.sv]
// channel | dir | payload                                             | handshake
// req     | in  | cmd[2:0], value[31:0]                               | valid/ready
// rsp     | out | accepted, front_value, rear_value, is_empty, is_full | valid/ready
// cfg     | in  | cfg_wdata[4:0] (capacity)                           | cfg_we
//
// A request is handled in order: accept, update pointers and write the slot, read
// both ends from the slot RAM (registered read port), then load the output register.
// Reset (rst, synchronous) empties the deque and sets capacity to 16, or to
// MAX_ENTRIES if smaller; slot contents are not cleared.
// A result waiting in the output register does not block the next request;
// that request stalls only in its final cycle until the register frees.
module circular_deque_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0] cfg_wdata,
  cdq_req_if.sink                   req,
  cdq_rsp_if.source                 rsp
);

  cdq_pkg::ctrl_cmd_t  ctrl;
  cdq_pkg::dp_status_t status;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  cdq_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_cmd      (req.cmd),
    .in_value    (req.value),
    .ctrl        (ctrl),
    .status      (status),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .accepted    (rsp.accepted),
    .front_value (rsp.front_value),
    .rear_value  (rsp.rear_value),
    .is_empty    (rsp.is_empty),
    .is_full     (rsp.is_full)
  );

endmodule

[rtl/cdq_checker.sv]
module cdq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic                              rsp_accepted,
  input logic signed [cdq_pkg::DATA_W-1:0] rsp_front_value,
  input logic signed [cdq_pkg::DATA_W-1:0] rsp_rear_value,
  input logic                              rsp_is_empty,
  input logic                              rsp_is_full
);

  // one request at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_empty |-> rsp_front_value == -1 && rsp_rear_value == -1)
    else $error("empty result carries element values");

  a_empty_not_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_is_empty && rsp_is_full))
    else $error("result is both empty and full");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
      && $stable(rsp_front_value) && $stable(rsp_rear_value))
    else $error("stalled result changed");

endmodule

bind circular_deque_core cdq_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_accepted    (rsp.accepted),
  .rsp_front_value (rsp.front_value),
  .rsp_rear_value  (rsp.rear_value),
  .rsp_is_empty    (rsp.is_empty),
  .rsp_is_full     (rsp.is_full)
);
